### sv/gpn_pkg.sv
`timescale 1ns / 1ps

package gpn_pkg;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_STORE = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNPLUGGED = 2'd1,
    STATUS_ERROR     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_LEFT_STICK  = 2'd0,
    REG_RIGHT_STICK = 2'd1,
    REG_TRIGGER     = 2'd2
  } reg_index_t;

  localparam logic [63:0] RangeReset = 64'hFFFF_0000_FFFF_0000;

  localparam int NumAxes   = 6;
  localparam int AxisBits  = $clog2(NumAxes);
  localparam int DivBits   = 16;
  localparam int DivRadix  = 2;
  localparam int DivCycles = DivBits / DivRadix;
  localparam int DivCntBits = $clog2(DivCycles);

  localparam logic [15:0] StickFloor   = 16'h8000;
  localparam logic [15:0] StickLow     = 16'h8001;
  localparam logic [15:0] QuotLow      = 16'h0000;
  localparam logic [15:0] QuotHigh     = 16'hFFFF;
  localparam logic [15:0] QuotCenter   = 16'h8000;

  localparam logic [11:0] ButtonGroup0 = 12'h00F;
  localparam logic [11:0] ButtonGroup1 = 12'h0F0;
  localparam logic [11:0] ButtonGroup2 = 12'hF00;

  localparam int HatFullTurn = 36000;
  localparam int HatSector   = HatFullTurn / 8;
  localparam int HatHalf     = HatSector / 2;
  localparam logic [15:0] HatCenter = 16'hFFFF;

  localparam logic [3:0] PadUp    = 4'b0001;
  localparam logic [3:0] PadDown  = 4'b0010;
  localparam logic [3:0] PadLeft  = 4'b0100;
  localparam logic [3:0] PadRight = 4'b1000;

  function automatic logic [3:0] pad_dir(input int sector);
    logic [3:0] d;
    case (sector)
      0:       d = PadUp;
      1:       d = PadUp | PadRight;
      2:       d = PadRight;
      3:       d = PadRight | PadDown;
      4:       d = PadDown;
      5:       d = PadDown | PadLeft;
      6:       d = PadLeft;
      7:       d = PadLeft | PadUp;
      8:       d = PadUp;
      default: d = 4'b0000;
    endcase
    return d;
  endfunction

  function automatic logic [3:0] hat_bits(input logic [15:0] angle);
    logic [3:0] bits;
    bits = 4'b0000;
    if (angle != HatCenter) begin
      for (int k = 8; k >= 0; k--) begin
        if ({1'b0, angle} < 17'(HatSector * k + HatHalf)) begin
          bits = pad_dir(k);
        end
      end
    end
    return bits;
  endfunction

  function automatic logic [15:0] pack_buttons(input logic [11:0] b, input logic [3:0] pad);
    logic [11:0] g0;
    logic [11:0] g1;
    logic [11:0] g2;
    g0 = b & ButtonGroup0;
    g1 = b & ButtonGroup1;
    g2 = b & ButtonGroup2;
    return {g0[3:0], g1[7:4], g2[11:8], pad};
  endfunction

endpackage

### sv/gamepad_report_normalizer.sv
`timescale 1ns / 1ps

// Gamepad report normalizer.
// Input channel (in_valid/in_ready) carries one raw joystick report; output
// channel (out_valid/out_ready) carries one normalized report per input.
// Configuration: cfg_write_en, cfg_index and cfg_data write one of the three
// 64-bit range registers; write only while no report is in flight.
// Processing: the six axes go one after another through one shared radix-4
// restoring divider. A normal axis goes through setup, the divide steps and
// store; an axis that is clamped or has equal bounds skips the divide steps.
// A report flagged unplugged or erroneous skips the axes and goes straight
// to its final step. in_ready is high only between reports, so the block
// takes no new report until it is through with the last one.
// The result sits in an output register: a stalled receiver does not stop the
// next report from being taken, but holds the block in its final step until
// the output register frees up.
// Reset clears the packet counter and returns the range registers to min 0,
// max 65535 on every axis.

module gamepad_report_normalizer #(
  parameter int POSITION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         report_status,
  input  logic [15:0]        x_position,
  input  logic [15:0]        y_position,
  input  logic [15:0]        z_position,
  input  logic [15:0]        r_position,
  input  logic [15:0]        u_position,
  input  logic [15:0]        v_position,
  input  logic [11:0]        raw_buttons,
  input  logic [15:0]        hat_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               report_valid,
  output logic [15:0]        button_word,
  output logic signed [15:0] left_x,
  output logic signed [15:0] left_y,
  output logic signed [15:0] right_x,
  output logic signed [15:0] right_y,
  output logic [7:0]         left_trigger,
  output logic [7:0]         right_trigger,
  output logic [31:0]        packet_number,
  input  logic               cfg_write_en,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam logic [15:0] PosMask = 16'((32'd1 << POSITION_BITS) - 1);
  localparam int AxisLast = gpn_pkg::NumAxes - 1;

  gpn_pkg::state_t state;
  gpn_pkg::state_t state_next;

  logic [63:0] ranges [3];
  logic [15:0] pos [gpn_pkg::NumAxes];
  logic [15:0] res [gpn_pkg::NumAxes];
  logic [gpn_pkg::AxisBits-1:0] axis;
  logic [gpn_pkg::DivCntBits-1:0] div_cnt;
  logic [15:0] rem;
  logic [15:0] quot;
  logic [15:0] den;
  logic        item_ok;
  logic [15:0] work_buttons;
  logic [31:0] work_count;
  logic [31:0] packet_counter;

  logic        accept;
  logic        out_free;
  logic [63:0] range_sel;
  logic [15:0] ax_v;
  logic [15:0] ax_lo;
  logic [15:0] ax_hi;
  logic [15:0] ax_diff;
  logic        ax_trig;
  logic        ax_neg;
  logic [31:0] ax_num;
  logic [15:0] rem_next;
  logic [15:0] quot_next;
  logic [16:0] trial;
  logic [15:0] store_val;

  assign in_ready = (state == gpn_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign range_sel = ranges[axis[2:1]];
  assign ax_v      = pos[axis] & PosMask;
  assign ax_lo     = (axis[0] ? range_sel[47:32] : range_sel[15:0]) & PosMask;
  assign ax_hi     = (axis[0] ? range_sel[63:48] : range_sel[31:16]) & PosMask;
  assign ax_diff   = ax_v - ax_lo;
  assign ax_trig   = axis[2];
  assign ax_neg    = axis[0] && !axis[2];
  assign ax_num    = ax_trig ? ({8'd0, ax_diff, 8'd0} - {16'd0, ax_diff})
                             : ({ax_diff, 16'd0} - {16'd0, ax_diff});

  always_comb begin
    rem_next  = rem;
    quot_next = quot;
    trial     = 17'd0;
    for (int i = 0; i < gpn_pkg::DivRadix; i++) begin
      trial     = {rem_next, quot_next[15]};
      quot_next = {quot_next[14:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        trial        = trial - {1'b0, den};
        quot_next[0] = 1'b1;
      end
      rem_next = trial[15:0];
    end
  end

  always_comb begin
    store_val = {~quot[15], quot[14:0]};
    if (store_val == gpn_pkg::StickFloor) begin
      store_val = gpn_pkg::StickLow;
    end
    if (ax_neg) begin
      store_val = -store_val;
    end
    if (ax_trig) begin
      store_val = {8'd0, quot[7:0]};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gpn_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (report_status == gpn_pkg::STATUS_OK) ? gpn_pkg::ST_LOAD
                                                            : gpn_pkg::ST_EMIT;
        end
      end
      gpn_pkg::ST_LOAD: begin
        if (ax_v < ax_lo || ax_v > ax_hi || ax_hi == ax_lo) begin
          state_next = gpn_pkg::ST_STORE;
        end else begin
          state_next = gpn_pkg::ST_DIV;
        end
      end
      gpn_pkg::ST_DIV: begin
        if (div_cnt == gpn_pkg::DivCntBits'(gpn_pkg::DivCycles - 1)) begin
          state_next = gpn_pkg::ST_STORE;
        end
      end
      gpn_pkg::ST_STORE: begin
        state_next = (axis == gpn_pkg::AxisBits'(AxisLast)) ? gpn_pkg::ST_EMIT
                                                           : gpn_pkg::ST_LOAD;
      end
      gpn_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = gpn_pkg::ST_IDLE;
        end
      end
      default: state_next = gpn_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= gpn_pkg::ST_IDLE;
      packet_counter <= 32'd0;
      out_valid      <= 1'b0;
      axis           <= '0;
      div_cnt        <= '0;
      for (int i = 0; i < 3; i++) begin
        ranges[i] <= gpn_pkg::RangeReset;
      end
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        case (cfg_index)
          gpn_pkg::REG_LEFT_STICK:  ranges[0] <= cfg_data;
          gpn_pkg::REG_RIGHT_STICK: ranges[1] <= cfg_data;
          gpn_pkg::REG_TRIGGER:     ranges[2] <= cfg_data;
          default: ;
        endcase
      end
      if (accept && report_status == gpn_pkg::STATUS_OK) begin
        packet_counter <= packet_counter + 32'd1;
      end
      if (accept) begin
        axis <= '0;
      end else if (state == gpn_pkg::ST_STORE && axis != gpn_pkg::AxisBits'(AxisLast)) begin
        axis <= axis + 1'b1;
      end
      if (state == gpn_pkg::ST_LOAD) begin
        div_cnt <= '0;
      end else if (state == gpn_pkg::ST_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end
      if (state == gpn_pkg::ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos[0]       <= x_position;
      pos[1]       <= y_position;
      pos[2]       <= z_position;
      pos[3]       <= r_position;
      pos[4]       <= u_position;
      pos[5]       <= v_position;
      item_ok      <= (report_status == gpn_pkg::STATUS_OK);
      work_buttons <= gpn_pkg::pack_buttons(raw_buttons, gpn_pkg::hat_bits(hat_angle));
      work_count   <= packet_counter + 32'd1;
    end
    case (state)
      gpn_pkg::ST_LOAD: begin
        den <= ax_hi - ax_lo;
        rem <= ax_num[31:16];
        if (ax_v < ax_lo) begin
          quot <= gpn_pkg::QuotLow;
        end else if (ax_v > ax_hi) begin
          quot <= gpn_pkg::QuotHigh;
        end else if (ax_hi == ax_lo) begin
          quot <= gpn_pkg::QuotCenter;
        end else begin
          quot <= ax_num[15:0];
        end
      end
      gpn_pkg::ST_DIV: begin
        rem  <= rem_next;
        quot <= quot_next;
      end
      gpn_pkg::ST_STORE: begin
        res[axis] <= store_val;
      end
      default: ;
    endcase
    if (state == gpn_pkg::ST_EMIT && out_free) begin
      report_valid  <= item_ok;
      button_word   <= item_ok ? work_buttons : 16'd0;
      left_x        <= item_ok ? $signed(res[0]) : 16'sd0;
      left_y        <= item_ok ? $signed(res[1]) : 16'sd0;
      right_x       <= item_ok ? $signed(res[2]) : 16'sd0;
      right_y       <= item_ok ? $signed(res[3]) : 16'sd0;
      left_trigger  <= item_ok ? res[4][7:0] : 8'd0;
      right_trigger <= item_ok ? res[5][7:0] : 8'd0;
      packet_number <= item_ok ? work_count : 32'd0;
    end
  end

`ifndef SYNTHESIS
  a_counter_advance: assert property (@(posedge clk) disable iff (rst)
    accept && report_status == gpn_pkg::STATUS_OK |=>
      packet_counter == $past(packet_counter) + 32'd1)
    else $error("packet counter did not advance on a valid report");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    state == gpn_pkg::ST_DIV |-> rem < den)
    else $error("divider remainder not below divisor");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    state == gpn_pkg::ST_LOAD |-> axis <= gpn_pkg::AxisBits'(AxisLast))
    else $error("axis index out of range");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    state == gpn_pkg::ST_EMIT && out_free |=> out_valid && in_ready)
    else $error("result transfer not presented after final step");
`endif

endmodule
